// ----- design/lpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types, constants and saturating helpers for the four-pole ladder
// lowpass: number formats, state memory map, multiplier request and FSM codes.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Number formats
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int STATE_WIDTH    = 32;
  localparam int STATE_FRAC     = STATE_WIDTH - 6;
  localparam int SAMPLE_FRAC    = SAMPLE_WIDTH - 1;
  localparam int FMT_SHIFT      = STATE_FRAC - SAMPLE_FRAC;

  // Coefficient register widths
  localparam int P_WIDTH = 21;
  localparam int K_WIDTH = 22;
  localparam int R_WIDTH = 23;

  // Configuration port
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 4;

  // Multiplier
  localparam int PROD_WIDTH  = 2 * STATE_WIDTH;
  localparam int RECIP_SHIFT = 34;
  // ceil(2^34 / 6): floor(n * RECIP_SIX / 2^34) == floor(n / 6) for n < 2^33
  localparam logic [STATE_WIDTH-1:0] RECIP_SIX = STATE_WIDTH'(64'd2863311531);
  localparam logic [PROD_WIDTH-1:0] COEF_RND  = PROD_WIDTH'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [PROD_WIDTH-1:0] STATE_RND = PROD_WIDTH'(1) << (STATE_FRAC - 1);
  localparam logic [STATE_WIDTH-1:0] CUBE_RND = STATE_WIDTH'(3);

  // State memory: stage outputs in the low half, previous stage inputs above
  localparam int STATE_DEPTH = 8;
  localparam int ADDR_WIDTH  = 3;
  localparam int STG_WIDTH   = 2;
  localparam logic SEL_SO  = 1'b0;
  localparam logic SEL_PIN = 1'b1;
  localparam logic [STG_WIDTH-1:0] LAST_STG = STG_WIDTH'(3);

  // Input item kinds
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic signed [STATE_WIDTH-1:0] state_word_t;
  typedef logic [ADDR_WIDTH-1:0]         ram_addr_t;

  typedef enum logic [1:0] {
    REG_COEF_P  = 2'd0,
    REG_COEF_K  = 2'd1,
    REG_COEF_R  = 2'd2,
    REG_ENABLED = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_COEF,
    MUL_STATE,
    MUL_RECIP
  } mul_mode_t;

  typedef struct packed {
    logic [STATE_WIDTH-1:0] a_mag;
    logic [STATE_WIDTH-1:0] b_mag;
    logic                   neg;
    mul_mode_t              mode;
  } mac_req_t;

  typedef struct packed {
    logic        we;
    ram_addr_t   addr;
    state_word_t data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_PIN,
    ST_FB_SUB,
    ST_STG_SUM,
    ST_STG_KSAVE,
    ST_STG_OUT,
    ST_CLIP_SQ,
    ST_CLIP_W1,
    ST_CLIP_CUBE,
    ST_CLIP_W2,
    ST_CLIP_DIV,
    ST_CLIP_W3,
    ST_CLIP_DONE,
    ST_OUT
  } seq_state_t;

  localparam state_word_t STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam state_word_t STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  // Saturate a one-bit-wider sum to the state width
  function automatic state_word_t sat_wide(input logic signed [STATE_WIDTH:0] v);
    if (v[STATE_WIDTH] != v[STATE_WIDTH-1]) begin
      return v[STATE_WIDTH] ? STATE_MIN : STATE_MAX;
    end
    return v[STATE_WIDTH-1:0];
  endfunction

  function automatic state_word_t sat_add(input state_word_t a, input state_word_t b);
    logic signed [STATE_WIDTH:0] s;
    s = (STATE_WIDTH+1)'(a) + (STATE_WIDTH+1)'(b);
    return sat_wide(s);
  endfunction

  function automatic state_word_t sat_sub(input state_word_t a, input state_word_t b);
    logic signed [STATE_WIDTH:0] s;
    s = (STATE_WIDTH+1)'(a) - (STATE_WIDTH+1)'(b);
    return sat_wide(s);
  endfunction

  // Magnitude; the most negative value maps to 2^(W-1)
  function automatic logic [STATE_WIDTH-1:0] mag_of(input state_word_t v);
    return v[STATE_WIDTH-1] ? STATE_WIDTH'(-v) : STATE_WIDTH'(v);
  endfunction

endpackage
`default_nettype wire

// ----- design/lpf_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_in_if
// Input channel: valid/ready handshake carrying one sample or clear command.
// ----------------------------------------------------------------------------
interface lpf_in_if;
  import lpf_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           last_in;

  modport source (output valid, kind, sample_in, last_in, input ready);
  modport sink   (input valid, kind, sample_in, last_in, output ready);
endinterface
`default_nettype wire

// ----- design/lpf_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_out_if
// Result channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
interface lpf_out_if;
  import lpf_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface
`default_nettype wire

// ----- design/lpf_state_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_state_ram
// Eight-word filter state memory, one write and one registered read port.
// Per-entry valid bits make a cleared or never-written entry read as zero.
// ----------------------------------------------------------------------------
module lpf_state_ram (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire lpf_pkg::ram_wr_t     wr,
  input  wire lpf_pkg::ram_addr_t   raddr,
  output lpf_pkg::state_word_t      rdata
);
  import lpf_pkg::*;

  state_word_t            mem [STATE_DEPTH];
  logic [STATE_DEPTH-1:0] valid_r;
  state_word_t            mem_q_r;
  logic                   rvalid_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // valid bits: reset and clear drop all entries at once
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    mem_q_r  <= mem[raddr];
    rvalid_r <= valid_r[raddr];
  end

  assign rdata = rvalid_r ? mem_q_r : '0;

endmodule
`default_nettype wire

// ----- design/lpf_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_mac
// Shared two-stage sign-magnitude multiplier. Stage one forms the exact
// product; stage two rounds (or floors, for the divide by six), applies the
// sign and saturates to the state width. Both stages end in a register.
// ----------------------------------------------------------------------------
module lpf_mac (
  input  wire logic               clk,
  input  wire lpf_pkg::mac_req_t  req,
  output lpf_pkg::state_word_t    res
);
  import lpf_pkg::*;

  logic [PROD_WIDTH-1:0] prod_nxt;
  logic [PROD_WIDTH-1:0] prod_r;
  logic                  neg_r;
  mul_mode_t             mode_r;
  logic [PROD_WIDTH-1:0] q;
  logic                  q_big;
  state_word_t           res_nxt;
  state_word_t           res_r;

  // stage one: exact magnitude product
  assign prod_nxt = PROD_WIDTH'(req.a_mag) * PROD_WIDTH'(req.b_mag);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= req.neg;
    mode_r <= req.mode;
  end

  // stage two: scale, sign, saturate
  always_comb begin
    case (mode_r)
      MUL_COEF:  q = (prod_r + COEF_RND) >> COEF_FRAC_BITS;
      MUL_STATE: q = (prod_r + STATE_RND) >> STATE_FRAC;
      MUL_RECIP: q = prod_r >> RECIP_SHIFT;
      default:   q = prod_r;
    endcase
    q_big = |q[PROD_WIDTH-1:STATE_WIDTH-1];
    if (neg_r) begin
      res_nxt = q_big ? STATE_MIN : state_word_t'(-q[STATE_WIDTH-1:0]);
    end else begin
      res_nxt = q_big ? STATE_MAX : state_word_t'(q[STATE_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- design/four_pole_ladder_lowpass_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass_core
// Four-pole resonant ladder lowpass with cubic soft clip on Q1.23 samples.
//
// Channels: in_ch takes audio samples (kind 0) or clear commands (kind 1);
// out_ch returns one output sample per audio sample, with last_in copied
// to last_out. Clear commands zero the eight state words and return nothing.
// The APB port (psel..prdata) holds coef_p, coef_k, coef_r and enabled at
// byte addresses 0, 4, 8 and 12; write them only while the filter is idle.
//
// Timing: one transaction in flight. A clear finishes in the cycle in which
// it is accepted. A pass-through sample (enabled = 0) is held in a result
// register and then moves to the output register. A filtered sample
// takes longer: the ladder is a chain of dependent products on one shared
// two-stage multiplier, with state read and written back through a
// registered-read memory. The next transaction is accepted once the
// previous result has moved into the output register, one sample at a time.
// Reset: registers and state read as zero, filter disabled, no result held.
// A stalled receiver keeps the result in the output register; a following
// transaction is accepted and computed, then waits until that slot frees.
// ----------------------------------------------------------------------------
module four_pole_ladder_lowpass_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lpf_in_if.sink                                  in_ch,
  lpf_out_if.source                               out_ch,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpf_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  wire logic [lpf_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic      [lpf_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                                    pready
);
  import lpf_pkg::*;

  localparam logic [STATE_WIDTH:0] OUT_RND = (STATE_WIDTH+1)'(1) << (FMT_SHIFT - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // configuration registers
  logic [P_WIDTH-1:0]        coef_p_r;
  logic signed [K_WIDTH-1:0] coef_k_r;
  logic [R_WIDTH-1:0]        coef_r_r;
  logic                      enabled_r;
  reg_idx_t                  reg_idx;
  logic                      cfg_wr;

  // sequencer
  seq_state_t                     state_r, state_nxt;
  logic [STG_WIDTH-1:0]           stg_r, stg_nxt;
  logic [STG_WIDTH-1:0]           stg_inc;
  state_word_t                    x_r, x_nxt;
  state_word_t                    cur_r, cur_nxt;
  state_word_t                    pin_r, pin_nxt;
  state_word_t                    kres_r, kres_nxt;
  logic                           last_r, last_nxt;
  logic signed [SAMPLE_WIDTH-1:0] res_sample_r, res_sample_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                           out_last_r, out_last_nxt;

  // datapath links
  mac_req_t    mac_req;
  state_word_t mac_res;
  ram_wr_t     ram_wr;
  ram_addr_t   ram_raddr;
  state_word_t ram_rdata;
  logic        ram_clr;
  state_word_t k_ext;
  state_word_t stg_sum;
  state_word_t stg_val;
  state_word_t clip_val;

  // Q6.26 to Q1.23, round half away from zero, saturate
  function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(input state_word_t y);
    logic [STATE_WIDTH:0] m;
    m = ((STATE_WIDTH+1)'(mag_of(y)) + OUT_RND) >> FMT_SHIFT;
    if (|m[STATE_WIDTH:SAMPLE_WIDTH-1]) begin
      return y[STATE_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return y[STATE_WIDTH-1] ? SAMPLE_WIDTH'(-m[SAMPLE_WIDTH-1:0])
                            : SAMPLE_WIDTH'(m[SAMPLE_WIDTH-1:0]);
  endfunction

  // signed state value times a magnitude with its own sign
  function automatic mac_req_t mk_req(input state_word_t a, input logic [STATE_WIDTH-1:0] b_mag,
                                      input logic b_neg, input mul_mode_t mode);
    mac_req_t r;
    r.a_mag = mag_of(a);
    r.b_mag = b_mag;
    r.neg   = a[STATE_WIDTH-1] ^ b_neg;
    r.mode  = mode;
    return r;
  endfunction

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_p_r  <= '0;
      coef_k_r  <= '0;
      coef_r_r  <= '0;
      enabled_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_P:  coef_p_r  <= pwdata[P_WIDTH-1:0];
        REG_COEF_K:  coef_k_r  <= pwdata[K_WIDTH-1:0];
        REG_COEF_R:  coef_r_r  <= pwdata[R_WIDTH-1:0];
        REG_ENABLED: enabled_r <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_P:  prdata = CFG_DATA_WIDTH'(coef_p_r);
      REG_COEF_K:  prdata = CFG_DATA_WIDTH'(coef_k_r);
      REG_COEF_R:  prdata = CFG_DATA_WIDTH'(coef_r_r);
      REG_ENABLED: prdata = CFG_DATA_WIDTH'(enabled_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- units
  lpf_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ram_clr),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpf_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  // shared arithmetic around the multiplier
  assign k_ext    = STATE_WIDTH'(coef_k_r);
  assign stg_inc  = stg_r + STG_WIDTH'(1);
  assign stg_sum  = sat_add(cur_r, pin_r);
  assign stg_val  = sat_sub(mac_res, kres_r);
  assign clip_val = sat_sub(cur_r, mac_res);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_r        <= stg_nxt;
    x_r          <= x_nxt;
    cur_r        <= cur_nxt;
    pin_r        <= pin_nxt;
    kres_r       <= kres_nxt;
    last_r       <= last_nxt;
    res_sample_r <= res_sample_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    stg_nxt        = stg_r;
    x_nxt          = x_r;
    cur_nxt        = cur_r;
    pin_nxt        = pin_r;
    kres_nxt       = kres_r;
    last_nxt       = last_r;
    res_sample_nxt = res_sample_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    mac_req        = mk_req(cur_r, '0, 1'b0, MUL_COEF);
    ram_wr         = '0;
    ram_raddr      = '0;
    ram_clr        = 1'b0;

    case (state_r)
      // take a transaction; start the feedback read of the last output
      ST_IDLE: begin
        if (in_ch.valid) begin
          last_nxt = in_ch.last_in;
          if (in_ch.kind == KIND_CLEAR) begin
            ram_clr = 1'b1;
          end else if (!enabled_r) begin
            res_sample_nxt = in_ch.sample_in;
            state_nxt      = ST_OUT;
          end else begin
            x_nxt     = STATE_WIDTH'(in_ch.sample_in) <<< FMT_SHIFT;
            ram_raddr = {SEL_SO, LAST_STG};
            stg_nxt   = '0;
            state_nxt = ST_FB_MUL;
          end
        end
      end
      // r times last output
      ST_FB_MUL: begin
        mac_req   = mk_req(ram_rdata, STATE_WIDTH'(coef_r_r), 1'b0, MUL_COEF);
        ram_raddr = {SEL_PIN, STG_WIDTH'(0)};
        state_nxt = ST_FB_PIN;
      end
      ST_FB_PIN: begin
        pin_nxt   = ram_rdata;
        ram_raddr = {SEL_SO, STG_WIDTH'(0)};
        state_nxt = ST_FB_SUB;
      end
      // ladder input; first k product
      ST_FB_SUB: begin
        cur_nxt   = sat_sub(x_r, mac_res);
        mac_req   = mk_req(ram_rdata, mag_of(k_ext), k_ext[STATE_WIDTH-1], MUL_COEF);
        state_nxt = ST_STG_SUM;
      end
      // p times (input + previous input); store this input
      ST_STG_SUM: begin
        mac_req     = mk_req(stg_sum, STATE_WIDTH'(coef_p_r), 1'b0, MUL_COEF);
        ram_wr.we   = 1'b1;
        ram_wr.addr = {SEL_PIN, stg_r};
        ram_wr.data = cur_r;
        if (stg_r != LAST_STG) begin
          ram_raddr = {SEL_PIN, stg_inc};
        end
        state_nxt = ST_STG_KSAVE;
      end
      ST_STG_KSAVE: begin
        kres_nxt = mac_res;
        if (stg_r != LAST_STG) begin
          pin_nxt   = ram_rdata;
          ram_raddr = {SEL_SO, stg_inc};
        end
        state_nxt = ST_STG_OUT;
      end
      // stage output; next stage's k product
      ST_STG_OUT: begin
        cur_nxt = stg_val;
        if (stg_r != LAST_STG) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = {SEL_SO, stg_r};
          ram_wr.data = stg_val;
          mac_req     = mk_req(ram_rdata, mag_of(k_ext), k_ext[STATE_WIDTH-1], MUL_COEF);
          stg_nxt     = stg_inc;
          state_nxt   = ST_STG_SUM;
        end else begin
          state_nxt = ST_CLIP_SQ;
        end
      end
      // soft clip: y^2, y^3, y^3 / 6
      ST_CLIP_SQ: begin
        mac_req   = mk_req(cur_r, mag_of(cur_r), cur_r[STATE_WIDTH-1], MUL_STATE);
        state_nxt = ST_CLIP_W1;
      end
      ST_CLIP_W1: begin
        state_nxt = ST_CLIP_CUBE;
      end
      ST_CLIP_CUBE: begin
        mac_req   = mk_req(mac_res, mag_of(cur_r), cur_r[STATE_WIDTH-1], MUL_STATE);
        state_nxt = ST_CLIP_W2;
      end
      ST_CLIP_W2: begin
        state_nxt = ST_CLIP_DIV;
      end
      ST_CLIP_DIV: begin
        mac_req.a_mag = mag_of(mac_res) + CUBE_RND;
        mac_req.b_mag = RECIP_SIX;
        mac_req.neg   = mac_res[STATE_WIDTH-1];
        mac_req.mode  = MUL_RECIP;
        state_nxt     = ST_CLIP_W3;
      end
      ST_CLIP_W3: begin
        state_nxt = ST_CLIP_DONE;
      end
      ST_CLIP_DONE: begin
        ram_wr.we      = 1'b1;
        ram_wr.addr    = {SEL_SO, LAST_STG};
        ram_wr.data    = clip_val;
        res_sample_nxt = to_sample(clip_val);
        state_nxt      = ST_OUT;
      end
      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_sample_r;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- channels
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.last_out   = out_last_r;

endmodule
`default_nettype wire
